### rtl/cbc_pkg.sv
package cbc_pkg;

  typedef enum logic [2:0] {
    CT_NONE = 3'd0,
    CT_MBC1 = 3'd1,
    CT_MBC2 = 3'd2,
    CT_MBC3 = 3'd3,
    CT_MBC5 = 3'd4
  } ctrl_type_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    TGT_SYSMEM = 3'd0,
    TGT_ROM    = 3'd1,
    TGT_RAM    = 3'd2,
    TGT_RTC    = 3'd3,
    TGT_CONST  = 3'd4,
    TGT_NONE   = 3'd5
  } target_e;

  localparam int PHYS_ADDR_W     = 23;
  localparam int ROM_OFFSET_BITS = 14;
  localparam int RAM_OFFSET_BITS = 13;
  localparam int RTC_REGS        = 5;

  typedef logic [8:0] rom_full_t;

  // Bus windows
  localparam logic [15:0] CTRL_EN_HI   = 16'h1FFF;
  localparam logic [15:0] CTRL_ROM_HI  = 16'h3FFF;
  localparam logic [15:0] MBC5_ROML_HI = 16'h2FFF;
  localparam logic [15:0] CTRL_RAM_HI  = 16'h5FFF;
  localparam logic [15:0] ROM_WIN_LO   = 16'h4000;
  localparam logic [15:0] ROM_WIN_HI   = 16'h7FFF;
  localparam logic [15:0] RAM_WIN_LO   = 16'hA000;
  localparam logic [15:0] RAM_WIN_HI   = 16'hBFFF;
  localparam logic [15:0] GAP_WIN_LO   = 16'hFEA0;
  localparam logic [15:0] GAP_WIN_HI   = 16'hFEFF;

  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0] RAM_DISABLE    = 8'h00;
  localparam logic [7:0] GAP_DATA       = 8'hFF;
  localparam logic [7:0] MBC1_LOW_MASK  = 8'h1F;
  localparam logic [7:0] MBC3_ROM_MASK  = 8'h7F;
  localparam logic [7:0] MBC3_BANK_HI   = 8'h07;
  localparam logic [7:0] RTC_SEL_FIRST  = 8'h08;
  localparam logic [7:0] RTC_SEL_LAST   = 8'h0C;
  localparam logic [7:0] MODE_MAX       = 8'h01;

  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;

  typedef struct packed {
    logic       tick;
    logic       wr;
    logic [2:0] idx;
    logic [7:0] wdata;
  } rtc_ctl_t;

endpackage

### rtl/cbc_if.sv
interface cbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] addr;
  logic [7:0]  wdata;

  modport source(output valid, req_type, addr, wdata, input ready);
  modport sink(input valid, req_type, addr, wdata, output ready);
endinterface

interface cbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [22:0] phys_addr;
  logic [7:0]  rdata;

  modport source(output valid, target, phys_addr, rdata, input ready);
  modport sink(input valid, target, phys_addr, rdata, output ready);
endinterface

interface cbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/cbc_rtc.sv
module cbc_rtc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbc_pkg::rtc_ctl_t ctl_i,
  input  logic [2:0]        rd_idx_i,
  output logic [7:0]        rd_data_o
);
  import cbc_pkg::*;

  logic [7:0] regs_q [RTC_REGS];
  logic [7:0] regs_d [RTC_REGS];

  logic [7:0] sec_inc, min_mid, hour_mid;
  logic       sec_wrap, min_wrap, hour_wrap;
  logic [8:0] day_cur, day_nxt;
  logic       day_ovf;

  // Seconds, minutes and hours ripple only on equality, so out-of-range
  // values written by software keep counting and wrap at 256.
  always_comb begin
    sec_inc   = regs_q[0] + 8'd1;
    sec_wrap  = (sec_inc == SEC_LIMIT);
    min_mid   = sec_wrap ? regs_q[1] + 8'd1 : regs_q[1];
    min_wrap  = (min_mid == MIN_LIMIT);
    hour_mid  = min_wrap ? regs_q[2] + 8'd1 : regs_q[2];
    hour_wrap = (hour_mid == HOUR_LIMIT);
    day_cur   = {regs_q[4][0], regs_q[3]};
    day_nxt   = day_cur + 9'd1;
    day_ovf   = &day_cur;
  end

  always_comb begin
    regs_d = regs_q;
    if (ctl_i.tick) begin
      regs_d[0] = sec_wrap ? 8'd0 : sec_inc;
      regs_d[1] = min_wrap ? 8'd0 : min_mid;
      regs_d[2] = hour_wrap ? 8'd0 : hour_mid;
      if (hour_wrap) begin
        regs_d[3] = day_nxt[7:0];
        regs_d[4] = {regs_q[4][7] | day_ovf, regs_q[4][6:1], day_nxt[8]};
      end
    end else if (ctl_i.wr && ctl_i.idx < 3'(RTC_REGS)) begin
      regs_d[ctl_i.idx] = ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RTC_REGS; i++) regs_q[i] <= 8'd0;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign rd_data_o = (rd_idx_i < 3'(RTC_REGS)) ? regs_q[rd_idx_i] : 8'd0;

endmodule

### rtl/cartridge_bank_controller_core.sv
// Cartridge bank controller: address translation and bank register updates.
// Latency: the result word for a request is registered at the edge that
// accepts it and is presented from the next cycle.
// Throughput: one request per cycle; a held result does not stall intake
// as long as the sink takes it in the same cycle.
// Reset: banks, enables, RTC select and clock registers return to defaults.
module cartridge_bank_controller_core #(
  parameter int ROM_BANK_BITS = 9,
  parameter int RAM_BANK_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbc_cfg_if.sink    cfg_i,
  cbc_req_if.sink    req_i,
  cbc_rsp_if.source  rsp_o
);
  import cbc_pkg::*;

  localparam rom_full_t ROM_MASK = rom_full_t'((1 << ROM_BANK_BITS) - 1);

  logic [2:0]               ctype_q;
  logic [ROM_BANK_BITS-1:0] rom_bank_q, rom_bank_d;
  logic [RAM_BANK_BITS-1:0] ram_bank_q, ram_bank_d;
  logic                     ram_on_q, ram_on_d;
  logic                     mode_q, mode_d;
  logic [3:0]               rtc_sel_q, rtc_sel_d;

  logic                     rsp_valid_q;
  logic [2:0]               target_q, target_d;
  logic [PHYS_ADDR_W-1:0]   phys_q, phys_d;
  logic [7:0]               rdata_q, rdata_d;

  logic                     req_fire, ctrl_wr, rtc_active;
  rom_full_t                rom_cur, rom_cand;
  logic [7:0]               rtc_rd;
  rtc_ctl_t                 rtc_ctl;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rtc_active = (ctype_q == CT_MBC3) && rtc_sel_q[3] && (rtc_sel_q[2:0] <= 3'd4);
  assign rom_cur    = rom_full_t'(rom_bank_q);

  // Result word
  always_comb begin
    target_d = TGT_NONE;
    phys_d   = '0;
    rdata_d  = 8'd0;
    ctrl_wr  = 1'b0;
    rtc_ctl  = '0;
    rtc_ctl.idx   = rtc_sel_q[2:0];
    rtc_ctl.wdata = req_i.wdata;
    case (req_i.req_type)
      REQ_READ: begin
        case (req_i.addr) inside
          [ROM_WIN_LO:ROM_WIN_HI]: begin
            target_d = TGT_ROM;
            phys_d   = PHYS_ADDR_W'({rom_bank_q, req_i.addr[ROM_OFFSET_BITS-1:0]});
          end
          [RAM_WIN_LO:RAM_WIN_HI]: begin
            if (!ram_on_q) begin
              target_d = TGT_CONST;
            end else if (rtc_active) begin
              target_d = TGT_RTC;
              rdata_d  = rtc_rd;
            end else begin
              target_d = TGT_RAM;
              phys_d   = PHYS_ADDR_W'({ram_bank_q, req_i.addr[RAM_OFFSET_BITS-1:0]});
            end
          end
          [GAP_WIN_LO:GAP_WIN_HI]: begin
            target_d = TGT_CONST;
            rdata_d  = GAP_DATA;
          end
          default: begin
            target_d = TGT_SYSMEM;
            phys_d   = PHYS_ADDR_W'(req_i.addr);
          end
        endcase
      end
      REQ_WRITE: begin
        case (req_i.addr) inside
          [16'h0000:ROM_WIN_HI]: begin
            ctrl_wr  = req_fire;
            target_d = TGT_NONE;
          end
          [RAM_WIN_LO:RAM_WIN_HI]: begin
            if (!ram_on_q) begin
              target_d = TGT_NONE;
            end else if (rtc_active) begin
              target_d   = TGT_RTC;
              rtc_ctl.wr = req_fire;
            end else begin
              target_d = TGT_RAM;
              phys_d   = PHYS_ADDR_W'({ram_bank_q, req_i.addr[RAM_OFFSET_BITS-1:0]});
            end
          end
          default: begin
            target_d = TGT_SYSMEM;
            phys_d   = PHYS_ADDR_W'(req_i.addr);
          end
        endcase
      end
      REQ_TICK: begin
        rtc_ctl.tick = req_fire;
      end
      default: begin
        target_d = TGT_NONE;
      end
    endcase
  end

  // Control register writes below 0x8000
  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    ram_on_d   = ram_on_q;
    mode_d     = mode_q;
    rtc_sel_d  = rtc_sel_q;
    rom_cand   = rom_cur;
    if (ctrl_wr) begin
      case (req_i.addr) inside
        [16'h0000:CTRL_EN_HI]: begin
          case (ctype_q)
            CT_MBC1: ram_on_d = (req_i.wdata == RAM_ENABLE_KEY);
            CT_MBC2: if (req_i.addr[8]) ram_on_d = !ram_on_q;
            CT_MBC3, CT_MBC5: begin
              if (req_i.wdata == RAM_ENABLE_KEY) ram_on_d = 1'b1;
              else if (req_i.wdata == RAM_DISABLE) ram_on_d = 1'b0;
            end
            default: ;
          endcase
        end
        [16'h2000:CTRL_ROM_HI]: begin
          case (ctype_q)
            CT_MBC1: begin
              rom_cand = ({rom_cur[8:5], 5'd0} | rom_full_t'(req_i.wdata & MBC1_LOW_MASK))
                         & ROM_MASK;
              // bump banks 0x00, 0x20, 0x40 and 0x60
              if (rom_cand[8:7] == 2'd0 && rom_cand[4:0] == 5'd0) rom_cand[0] = 1'b1;
              rom_bank_d = rom_cand[ROM_BANK_BITS-1:0];
            end
            CT_MBC2: begin
              if (req_i.addr[8]) rom_bank_d = ROM_BANK_BITS'(req_i.wdata[3:0]);
            end
            CT_MBC3: begin
              rom_cand = rom_full_t'(req_i.wdata & MBC3_ROM_MASK) & ROM_MASK;
              if (rom_cand == '0) rom_cand = rom_full_t'(1);
              rom_bank_d = rom_cand[ROM_BANK_BITS-1:0];
            end
            CT_MBC5: begin
              if (req_i.addr <= MBC5_ROML_HI) rom_cand = {rom_cur[8], req_i.wdata};
              else rom_cand = {req_i.wdata[0], rom_cur[7:0]};
              rom_bank_d = rom_cand[ROM_BANK_BITS-1:0];
            end
            default: ;
          endcase
        end
        [16'h4000:CTRL_RAM_HI]: begin
          case (ctype_q)
            CT_MBC1: begin
              if (mode_q) begin
                ram_bank_d = RAM_BANK_BITS'(req_i.wdata[1:0]);
              end else begin
                rom_cand   = {rom_cur[8:7], req_i.wdata[1:0], rom_cur[4:0]} & ROM_MASK;
                rom_bank_d = rom_cand[ROM_BANK_BITS-1:0];
              end
            end
            CT_MBC3: begin
              case (req_i.wdata) inside
                [8'h00:MBC3_BANK_HI]: begin
                  ram_bank_d = RAM_BANK_BITS'(req_i.wdata[2:0]);
                  rtc_sel_d  = 4'd0;
                end
                [RTC_SEL_FIRST:RTC_SEL_LAST]: rtc_sel_d = req_i.wdata[3:0];
                default: ;
              endcase
            end
            CT_MBC5: ram_bank_d = RAM_BANK_BITS'(req_i.wdata[3:0]);
            default: ;
          endcase
        end
        default: begin
          if (ctype_q == CT_MBC1 && req_i.wdata <= MODE_MAX) mode_d = req_i.wdata[0];
        end
      endcase
    end
  end

  cbc_rtc u_rtc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rtc_ctl),
    .rd_idx_i (rtc_sel_q[2:0]),
    .rd_data_o(rtc_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctype_q    <= CT_NONE;
      rom_bank_q <= ROM_BANK_BITS'(1);
      ram_bank_q <= '0;
      ram_on_q   <= 1'b0;
      mode_q     <= 1'b0;
      rtc_sel_q  <= 4'd0;
    end else begin
      if (cfg_i.valid) ctype_q <= cfg_i.data;
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      ram_on_q   <= ram_on_d;
      mode_q     <= mode_d;
      rtc_sel_q  <= rtc_sel_d;
    end
  end

  // Output word register; refill on the same edge it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      target_q <= target_d;
      phys_q   <= phys_d;
      rdata_q  <= rdata_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.target    = target_q;
  assign rsp_o.phys_addr = phys_q;
  assign rsp_o.rdata     = rdata_q;

endmodule

### verif/cbc_bank_tracker.sv
module cbc_bank_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  cbc_cfg_if   cfg_i,
  cbc_req_if   req_i,
  cbc_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  typedef struct packed {
    target_e                target;
    logic [PHYS_ADDR_W-1:0] phys_addr;
    logic [7:0]             rdata;
  } bus_word_t;

  ctrl_type_e ctrl_kind;
  rom_full_t  rom_sel;
  logic [3:0] ram_sel;
  logic       ram_open;
  logic       mode_ram;
  logic [3:0] clk_sel;
  logic [7:0] clock_reg [RTC_REGS];

  bus_word_t  due_words [$];
  int         fails;
  int         checked;

  function automatic bus_word_t make_word(target_e t, logic [PHYS_ADDR_W-1:0] pa,
                                          logic [7:0] d);
    bus_word_t w;
    w.target    = t;
    w.phys_addr = pa;
    w.rdata     = d;
    return w;
  endfunction

  function automatic bit in_ram_window(logic [15:0] a);
    return a >= RAM_WIN_LO && a <= RAM_WIN_HI;
  endfunction

  function automatic bit clock_mapped();
    return ctrl_kind == CT_MBC3 && clk_sel >= RTC_SEL_FIRST && clk_sel <= RTC_SEL_LAST;
  endfunction

  // Counters are plain 8-bit and only compared for equality, so out-of-range
  // values keep counting and wrap.
  function automatic void advance_clock();
    logic [8:0] day;
    clock_reg[0] = clock_reg[0] + 8'd1;
    if (clock_reg[0] == SEC_LIMIT) begin
      clock_reg[0] = 8'd0;
      clock_reg[1] = clock_reg[1] + 8'd1;
    end
    if (clock_reg[1] == MIN_LIMIT) begin
      clock_reg[1] = 8'd0;
      clock_reg[2] = clock_reg[2] + 8'd1;
    end
    if (clock_reg[2] == HOUR_LIMIT) begin
      clock_reg[2] = 8'd0;
      day = {clock_reg[4][0], clock_reg[3]};
      if (day == 9'h1FF) begin
        day = 9'd0;
        clock_reg[4][7] = 1'b1;
      end else begin
        day = day + 9'd1;
      end
      clock_reg[3]    = day[7:0];
      clock_reg[4][0] = day[8];
    end
  endfunction

  function automatic void update_banks(logic [15:0] a, logic [7:0] v);
    if (a <= CTRL_EN_HI) begin
      case (ctrl_kind)
        CT_MBC1: ram_open = (v == RAM_ENABLE_KEY);
        CT_MBC2: if (a[8]) ram_open = !ram_open;
        CT_MBC3, CT_MBC5: begin
          if (v == RAM_ENABLE_KEY) ram_open = 1'b1;
          else if (v == RAM_DISABLE) ram_open = 1'b0;
        end
        default: ;
      endcase
    end else if (a <= CTRL_ROM_HI) begin
      case (ctrl_kind)
        CT_MBC1: begin
          rom_sel = {rom_sel[8:5], v[4:0]};
          // bump banks 0x00/0x20/0x40/0x60
          if (rom_sel[4:0] == 5'd0 && rom_sel[8:7] == 2'd0) rom_sel = rom_sel + 9'd1;
        end
        CT_MBC2: if (a[8]) rom_sel = {5'd0, v[3:0]};
        CT_MBC3: begin
          rom_sel = {2'd0, v[6:0]};
          if (rom_sel == '0) rom_sel = 9'd1;
        end
        CT_MBC5: begin
          if (a <= MBC5_ROML_HI) rom_sel[7:0] = v;
          else rom_sel[8] = v[0];
        end
        default: ;
      endcase
    end else if (a <= CTRL_RAM_HI) begin
      case (ctrl_kind)
        CT_MBC1: begin
          if (mode_ram) ram_sel = {2'd0, v[1:0]};
          else rom_sel[6:5] = v[1:0];
        end
        CT_MBC3: begin
          if (v <= MBC3_BANK_HI) begin
            ram_sel = v[3:0];
            clk_sel = 4'd0;
          end else if (v <= RTC_SEL_LAST) begin
            clk_sel = v[3:0];
          end
        end
        CT_MBC5: ram_sel = v[3:0];
        default: ;
      endcase
    end else if (ctrl_kind == CT_MBC1 && v <= MODE_MAX) begin
      mode_ram = v[0];
    end
  endfunction

  function automatic bus_word_t translate_access(logic [1:0] rt, logic [15:0] a,
                                                 logic [7:0] v);
    logic [PHYS_ADDR_W-1:0] ram_addr;
    logic [PHYS_ADDR_W-1:0] rom_addr;
    bus_word_t              word;
    ram_addr = {6'd0, ram_sel, a[RAM_OFFSET_BITS-1:0]};
    rom_addr = {rom_sel, a[ROM_OFFSET_BITS-1:0]};
    word     = make_word(TGT_NONE, '0, '0);
    case (rt)
      REQ_READ: begin
        if (a >= ROM_WIN_LO && a <= ROM_WIN_HI) begin
          word = make_word(TGT_ROM, rom_addr, '0);
        end else if (in_ram_window(a)) begin
          if (!ram_open) word = make_word(TGT_CONST, '0, '0);
          else if (clock_mapped())
            word = make_word(TGT_RTC, '0, clock_reg[clk_sel - RTC_SEL_FIRST[3:0]]);
          else word = make_word(TGT_RAM, ram_addr, '0);
        end else if (a >= GAP_WIN_LO && a <= GAP_WIN_HI) begin
          word = make_word(TGT_CONST, '0, GAP_DATA);
        end else begin
          word = make_word(TGT_SYSMEM, {7'd0, a}, '0);
        end
      end
      REQ_WRITE: begin
        if (a <= ROM_WIN_HI) begin
          update_banks(a, v);
        end else if (in_ram_window(a)) begin
          if (ram_open && clock_mapped()) begin
            clock_reg[clk_sel - RTC_SEL_FIRST[3:0]] = v;
            word = make_word(TGT_RTC, '0, '0);
          end else if (ram_open) begin
            word = make_word(TGT_RAM, ram_addr, '0);
          end
        end else begin
          word = make_word(TGT_SYSMEM, {7'd0, a}, '0);
        end
      end
      REQ_TICK: advance_clock();
      default: ;
    endcase
    return word;
  endfunction

  function automatic void compare_field(string label, logic [PHYS_ADDR_W-1:0] want,
                                        logic [PHYS_ADDR_W-1:0] seen);
    if (seen !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, seen);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_word_t seen;
    bus_word_t want;
    if (!rst_ni) begin
      ctrl_kind = CT_NONE;
      rom_sel   = 9'd1;
      ram_sel   = 4'd0;
      ram_open  = 1'b0;
      mode_ram  = 1'b0;
      clk_sel   = 4'd0;
      for (int i = 0; i < RTC_REGS; i++) clock_reg[i] = 8'd0;
      due_words.delete();
      fails   = 0;
      checked = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      // compare before predicting: a word never leaves in its own accept cycle
      if (rsp_i.valid && rsp_i.ready) begin
        seen.target    = target_e'(rsp_i.target);
        seen.phys_addr = rsp_i.phys_addr;
        seen.rdata     = rsp_i.rdata;
        if (due_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, actual target %0d addr 0x%0h data 0x%0h",
                   $time, rsp_i.target, rsp_i.phys_addr, rsp_i.rdata);
        end else begin
          want = due_words.pop_front();
          compare_field("target", PHYS_ADDR_W'(want.target), PHYS_ADDR_W'(rsp_i.target));
          compare_field("phys_addr", want.phys_addr, seen.phys_addr);
          compare_field("rdata", PHYS_ADDR_W'(want.rdata), PHYS_ADDR_W'(rsp_i.rdata));
          checked++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) ctrl_kind = ctrl_type_e'(cfg_i.data);
      if (req_i.valid && req_i.ready)
        due_words.push_back(translate_access(req_i.req_type, req_i.addr, req_i.wdata));
      mismatches_o  <= fails;
      outstanding_o <= due_words.size();
      checked_o     <= checked;
    end
  end

endmodule

### verif/cartridge_bank_controller_core_tb.sv
module cartridge_bank_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         RANDOM_ITEMS = 1550;
  localparam int         PHASES      = 20;

  localparam logic [15:0] BOUNDARY_ADDRS [20] = '{
    16'h0000, 16'h1FFF, 16'h2000, 16'h2FFF, 16'h3000, 16'h3FFF, 16'h4000,
    16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF,
    16'hC000, 16'hFE9F, 16'hFEA0, 16'hFEFF, 16'hFF00, 16'hFFFF
  };

  logic clk_i;
  logic rst_ni;

  cbc_cfg_if cfg_bus ();
  cbc_req_if req_bus ();
  cbc_rsp_if rsp_bus ();

  int mismatches;
  int outstanding;
  int checked;

  bit         steady;
  ctrl_type_e current_kind;
  int         sent;
  int         n_reads;
  int         n_writes;
  int         n_ticks;
  int         n_spare;
  int         n_switches;
  int         quiet;

  cartridge_bank_controller_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  cbc_bank_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_bus),
    .req_i         (req_bus),
    .rsp_i         (rsp_bus),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always begin
    clk_i = 1'b0;
    #10ns;
    clk_i = 1'b1;
    #10ns;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, ROM_WIN_HI));
      1: return 16'($urandom_range(ROM_WIN_LO, ROM_WIN_HI));
      2: return 16'($urandom_range(RAM_WIN_LO, RAM_WIN_HI));
      3: return 16'($urandom_range(GAP_WIN_LO, GAP_WIN_HI));
      4: return BOUNDARY_ADDRS[$urandom_range(0, 19)];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return RAM_ENABLE_KEY;
      1: return RAM_DISABLE;
      2, 3: return 8'($urandom_range(0, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  // Bias clock writes to one below the rollover point so ticks carry upward.
  function automatic logic [7:0] near_limit(int k);
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    case (k)
      0: return SEC_LIMIT - 8'd1;
      1: return MIN_LIMIT - 8'd1;
      2: return HOUR_LIMIT - 8'd1;
      3: return 8'hFF;
      default: return {1'($urandom_range(0, 1)), 6'd0, 1'b1};
    endcase
  endfunction

  task automatic send_access(input logic [1:0] kind, input logic [15:0] a,
                             input logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.addr     <= a;
    req_bus.wdata    <= d;
    do @(posedge clk_i); while (!req_bus.ready);
    sent++;
    case (kind)
      REQ_READ:  n_reads++;
      REQ_WRITE: n_writes++;
      REQ_TICK:  n_ticks++;
      default:   n_spare++;
    endcase
  endtask

  // Drop valid and hold until every result word is back.
  task automatic settle();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic switch_controller(input ctrl_type_e kind);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= kind;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    current_kind = kind;
    n_switches++;
  endtask

  task automatic clock_sequence();
    int n;
    send_access(REQ_WRITE, 16'($urandom_range(0, CTRL_EN_HI)), RAM_ENABLE_KEY);
    n = $urandom_range(0, 1);
    for (int k = 0; k < RTC_REGS; k++) begin
      if (n == 1 || $urandom_range(0, 3) != 0) begin
        send_access(REQ_WRITE, 16'($urandom_range(16'h4000, CTRL_RAM_HI)),
                    RTC_SEL_FIRST + 8'(k));
        send_access(REQ_WRITE, 16'($urandom_range(RAM_WIN_LO, RAM_WIN_HI)), near_limit(k));
      end
    end
    repeat ($urandom_range(1, 3)) send_access(REQ_TICK, 16'($urandom), 8'($urandom));
    send_access(REQ_WRITE, 16'($urandom_range(16'h4000, CTRL_RAM_HI)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(RTC_SEL_FIRST, RTC_SEL_LAST)));
    send_access(REQ_READ, 16'($urandom_range(RAM_WIN_LO, RAM_WIN_HI)), 8'($urandom));
  endtask

  task automatic run_burst();
    int pick;
    pick = $urandom_range(0, 9);
    if (current_kind == CT_MBC3 && pick >= 6) pick = 9;
    case (pick)
      0, 1: send_access(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      2, 3: send_access(REQ_WRITE, 16'($urandom_range(0, ROM_WIN_HI)), pick_byte());
      4, 5, 6: begin
        repeat ($urandom_range(1, 4))
          send_access($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, pick_addr(),
                      8'($urandom));
      end
      7: begin
        send_access(REQ_WRITE, 16'($urandom_range(0, CTRL_EN_HI)),
                    $urandom_range(0, 2) != 0 ? RAM_ENABLE_KEY : pick_byte());
        repeat ($urandom_range(1, 3))
          send_access($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                      16'($urandom_range(RAM_WIN_LO, RAM_WIN_HI)), 8'($urandom));
      end
      8: begin
        send_access(REQ_WRITE, 16'($urandom_range(16'h2000, CTRL_ROM_HI)), 8'($urandom));
        send_access(REQ_READ, 16'($urandom_range(ROM_WIN_LO, ROM_WIN_HI)), 8'($urandom));
        send_access(REQ_WRITE, 16'($urandom_range(16'h6000, ROM_WIN_HI)),
                    8'($urandom_range(0, 2)));
        send_access(REQ_WRITE, 16'($urandom_range(16'h4000, CTRL_RAM_HI)), pick_byte());
        send_access(REQ_READ, 16'($urandom_range(RAM_WIN_LO, RAM_WIN_HI)), 8'($urandom));
      end
      default: clock_sequence();
    endcase
  endtask

  initial begin
    forever begin
      rsp_bus.ready <= 1'b1;
      repeat (steady ? $urandom_range(20, 80) : $urandom_range(1, 8)) @(posedge clk_i);
      if (pick_gap() > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("cartridge_bank_controller_core_tb: errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int phase_end;
    rst_ni           = 1'b0;
    steady           = 1'b0;
    sent             = 0;
    n_reads          = 0;
    n_writes         = 0;
    n_ticks          = 0;
    n_spare          = 0;
    n_switches       = 0;
    current_kind     = CT_NONE;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_READ;
    req_bus.addr     <= '0;
    req_bus.wdata    <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.data     <= CT_NONE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    switch_controller(CT_NONE);
    send_access(REQ_READ, 16'h0000, 8'h00);
    send_access(REQ_READ, 16'hFFFF, 8'hFF);
    send_access(REQ_READ, GAP_WIN_LO, 8'h00);
    send_access(REQ_READ, GAP_WIN_HI, 8'h00);
    send_access(REQ_READ, RAM_WIN_LO, 8'h00);
    send_access(REQ_WRITE, 16'h2000, 8'h05);
    send_access(REQ_READ, ROM_WIN_LO, 8'h00);
    send_access(REQ_SPARE, ROM_WIN_HI, 8'hFF);
    send_access(REQ_TICK, 16'hFFFF, 8'hFF);

    switch_controller(CT_MBC1);
    send_access(REQ_WRITE, 16'h0000, RAM_ENABLE_KEY);
    send_access(REQ_WRITE, 16'h4000, 8'h01);
    // low bits zero on upper bank 1: lands on 0x20 and bumps
    send_access(REQ_WRITE, 16'h2000, 8'h00);
    send_access(REQ_READ, ROM_WIN_HI, 8'h00);
    send_access(REQ_WRITE, 16'h6000, 8'h02);
    send_access(REQ_WRITE, 16'h7FFF, 8'h01);
    send_access(REQ_WRITE, 16'h5FFF, 8'h03);
    send_access(REQ_READ, RAM_WIN_HI, 8'h00);

    switch_controller(CT_MBC2);
    send_access(REQ_WRITE, 16'h0100, 8'h00);
    send_access(REQ_WRITE, 16'h1EFF, RAM_ENABLE_KEY);
    send_access(REQ_WRITE, 16'h3100, 8'hFF);
    send_access(REQ_READ, RAM_WIN_LO, 8'h00);

    switch_controller(CT_MBC5);
    send_access(REQ_WRITE, 16'h3000, 8'hFF);
    send_access(REQ_WRITE, 16'h2000, 8'hFF);
    send_access(REQ_READ, ROM_WIN_HI, 8'h00);
    send_access(REQ_WRITE, 16'h4000, 8'hFF);
    send_access(REQ_WRITE, CTRL_EN_HI, RAM_ENABLE_KEY);
    send_access(REQ_READ, RAM_WIN_HI, 8'h00);

    for (ph = 0; ph < PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      switch_controller(ph < 5 ? ctrl_type_e'(3'(ph)) : ctrl_type_e'(3'($urandom_range(0, 4))));
      phase_end = sent + RANDOM_ITEMS / PHASES;
      while (sent < phase_end) run_burst();
    end

    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    $display("%0d requests: %0d reads, %0d writes, %0d ticks, %0d unused codes; %0d checked",
             sent, n_reads, n_writes, n_ticks, n_spare, checked);
    $display("%0d controller type changes across none, MBC1, MBC2, MBC3 and MBC5",
             n_switches);
    if (mismatches == 0 && outstanding == 0)
      $display("cartridge_bank_controller_core_tb: clean");
    else
      $display("cartridge_bank_controller_core_tb: errors");
    $finish;
  end

endmodule

### sim.f
rtl/cbc_pkg.sv
rtl/cbc_if.sv
rtl/cbc_rtc.sv
rtl/cartridge_bank_controller_core.sv
verif/cbc_bank_tracker.sv
verif/cartridge_bank_controller_core_tb.sv
